// File: rtl/vgmp_pkg.sv
package vgmp_pkg;

    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FORMAT_VERSION = 3'd0,
        CFG_DATA_START     = 3'd1,
        CFG_END_BOUND      = 3'd2,
        CFG_LOOP_TARGET    = 3'd3,
        CFG_FILE_LENGTH    = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_EXHAUST = 2'd1,
        ACT_START   = 2'd2,
        ACT_IGNORE  = 2'd3
    } t_action;

    localparam logic [2:0] KIND_REG_WRITE = 3'd0;
    localparam logic [2:0] KIND_WAIT      = 3'd1;
    localparam logic [2:0] KIND_LOOP_JUMP = 3'd2;
    localparam logic [2:0] KIND_END       = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    localparam logic [1:0] ERR_TRUNCATED  = 2'd0;
    localparam logic [1:0] ERR_BLOCK_RANGE = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN_OP = 2'd2;
    localparam logic [1:0] ERR_LOOP_RANGE = 2'd3;

    localparam logic [7:0]  OP_YM2151_WRITE = 8'h54;
    localparam logic [7:0]  OP_WAIT_N       = 8'h61;
    localparam logic [7:0]  OP_WAIT_NTSC    = 8'h62;
    localparam logic [7:0]  OP_WAIT_PAL     = 8'h63;
    localparam logic [7:0]  OP_END          = 8'h66;
    localparam logic [7:0]  OP_DATA_BLOCK   = 8'h67;
    localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
    localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;
    localparam logic [31:0] BLOCK_SIZE_MASK   = 32'h7FFF_FFFF;
    localparam logic [15:0] VERSION_WIDE_OPS  = 16'h0160;

    localparam logic [15:0] RST_FORMAT_VERSION = 16'h0170;
    localparam logic [31:0] RST_DATA_START     = 32'd64;
    localparam logic [31:0] RST_END_BOUND      = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_LOOP_TARGET    = 32'd0;
    localparam logic [31:0] RST_FILE_LENGTH    = 32'hFFFF_FFFF;

    // operand counts of the DAC stream control opcodes 0x90..0x95
    localparam logic [3:0] DAC_CTL_LEN [6] = '{4'd4, 4'd4, 4'd5, 4'd10, 4'd1, 4'd4};

    typedef enum logic [3:0] {
        PH_OPCODE   = 4'd0,
        PH_REG_ADDR = 4'd1,
        PH_REG_DATA = 4'd2,
        PH_WAIT_LO  = 4'd3,
        PH_WAIT_HI  = 4'd4,
        PH_BLK_HDR  = 4'd5,
        PH_BLK_SIZE = 4'd6,
        PH_SKIP     = 4'd8
    } t_phase;

    typedef struct packed {
        logic [15:0] format_version;
        logic [31:0] data_start;
        logic [31:0] end_bound;
        logic [31:0] loop_target;
        logic [31:0] file_length;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  reg_address;
        logic [7:0]  reg_data;
        logic [15:0] wait_samples;
        logic [63:0] sample_position;
        logic [31:0] loop_count;
        logic [1:0]  error_code;
        logic [31:0] error_offset;
        logic [31:0] jump_offset;
    } t_result;

    typedef struct packed {
        logic       known;
        logic [3:0] len;
    } t_op_len;

    // operand byte count of an opcode whose operands are skipped
    function automatic t_op_len op_len(input logic [7:0] op, input logic [15:0] version);
        t_op_len r;
        r.known = 1'b1;
        r.len   = 4'd0;
        if (op <= 8'h2F) begin
            r.known = 1'b0;
        end else if (op <= 8'h3F) begin
            r.len = 4'd1;
        end else if (op <= 8'h4E) begin
            r.len = (version >= VERSION_WIDE_OPS) ? 4'd2 : 4'd1;
        end else if (op <= 8'h50) begin
            r.len = 4'd1;
        end else if (op <= 8'h5F) begin
            r.len = 4'd2;
        end else if (op == 8'h64) begin
            r.len = 4'd3;
        end else if (op == 8'h68) begin
            r.len = 4'd11;
        end else if (op >= 8'h90 && op <= 8'h95) begin
            r.len = DAC_CTL_LEN[op[2:0]];
        end else if (op >= 8'hA0 && op <= 8'hBF) begin
            r.len = 4'd2;
        end else if (op >= 8'hC0 && op <= 8'hDF) begin
            r.len = 4'd3;
        end else if (op >= 8'hE0) begin
            r.len = 4'd4;
        end else begin
            r.known = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/vgm_command_stream_parser.sv
// VGM command stream parser: takes one file byte (or a start / end-of-stream
// action) per item and returns YM2151 register writes, waits, loop jumps, end
// of data and errors. Throughput is one item per clock unless the output
// register stalls: an input register feeds a combinational parse stage, whose
// state advances as the item leaves the input register, and the result lands
// in an output register. Only a stalled output register holds the input side.
// After a loop jump the feeder must resume at jump_offset. Configuration
// registers are to be written through the plain write port only while the
// block is idle; the block itself does not enforce this.
module vgm_command_stream_parser
    import vgmp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_action,
    input  logic [7:0]             i_byte_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0]             o_kind,
    output logic [7:0]             o_reg_address,
    output logic [7:0]             o_reg_data,
    output logic [15:0]            o_wait_samples,
    output logic [63:0]            o_sample_position,
    output logic [31:0]            o_loop_count,
    output logic [1:0]             o_error_code,
    output logic [31:0]            o_error_offset,
    output logic [31:0]            o_jump_offset
);

    t_cfg    r_cfg;
    logic    item_valid;
    logic [1:0] item_action;
    logic [7:0] item_byte;
    logic    out_free;
    logic    advance;
    logic    res_valid;
    t_result result;
    t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.format_version <= RST_FORMAT_VERSION;
            r_cfg.data_start     <= RST_DATA_START;
            r_cfg.end_bound      <= RST_END_BOUND;
            r_cfg.loop_target    <= RST_LOOP_TARGET;
            r_cfg.file_length    <= RST_FILE_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FORMAT_VERSION: r_cfg.format_version <= i_cfg_wdata[15:0];
                CFG_DATA_START:     r_cfg.data_start     <= i_cfg_wdata;
                CFG_END_BOUND:      r_cfg.end_bound      <= i_cfg_wdata;
                CFG_LOOP_TARGET:    r_cfg.loop_target    <= i_cfg_wdata;
                CFG_FILE_LENGTH:    r_cfg.file_length    <= i_cfg_wdata;
                default:            r_cfg.format_version <= r_cfg.format_version;
            endcase
        end
    end

    assign advance = item_valid && out_free;

    vgmp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_advance    (advance),
        .o_valid      (item_valid),
        .o_action     (item_action),
        .o_byte_value (item_byte)
    );

    vgmp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_advance    (advance),
        .i_action     (item_action),
        .i_byte_value (item_byte),
        .o_res_valid  (res_valid),
        .o_result     (result)
    );

    vgmp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && res_valid),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_kind            = out_result.kind;
    assign o_reg_address     = out_result.reg_address;
    assign o_reg_data        = out_result.reg_data;
    assign o_wait_samples    = out_result.wait_samples;
    assign o_sample_position = out_result.sample_position;
    assign o_loop_count      = out_result.loop_count;
    assign o_error_code      = out_result.error_code;
    assign o_error_offset    = out_result.error_offset;
    assign o_jump_offset     = out_result.jump_offset;

endmodule

// File: rtl/vgmp_in_reg.sv
module vgmp_in_reg
    import vgmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_byte_value,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [1:0] o_action,
    output logic [7:0] o_byte_value
);

    logic       r_valid;
    logic [1:0] r_action;
    logic [7:0] r_byte_value;
    logic       load;

    assign o_ready = !r_valid || i_advance;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_action     <= i_action;
            r_byte_value <= i_byte_value;
        end
    end

    assign o_valid      = r_valid;
    assign o_action     = r_action;
    assign o_byte_value = r_byte_value;

endmodule

// File: rtl/vgmp_core.sv
module vgmp_core
    import vgmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_advance,
    input  logic [1:0] i_action,
    input  logic [7:0] i_byte_value,
    output logic       o_res_valid,
    output t_result    o_result
);

    logic        r_running,       n_running;
    t_phase      r_phase,         n_phase;
    logic [31:0] r_file_position, n_file_position;
    logic [31:0] r_command_start, n_command_start;
    logic [7:0]  r_first_operand, n_first_operand;
    logic [31:0] r_skip_remaining, n_skip_remaining;
    logic [31:0] r_block_length,  n_block_length;
    logic [63:0] r_samples_total, n_samples_total;
    logic [31:0] r_loops_taken,   n_loops_taken;

    logic [31:0] pos_inc;
    t_op_len     op_info;
    logic [1:0]  size_idx;
    logic [31:0] size_acc;
    logic [31:0] size_masked;
    logic [32:0] block_end;

    logic        emit_wait;
    logic [15:0] wait_amt;
    logic        emit_reg;
    logic        end_req;
    logic [31:0] end_at;
    logic        emit_jump;
    logic        emit_stop;
    logic        fail_req;
    logic [1:0]  fail_code;
    logic [31:0] fail_at;

    assign pos_inc     = r_file_position + 32'd1;
    assign op_info     = op_len(i_byte_value, i_cfg.format_version);
    assign size_idx    = 2'(32'd4 - r_skip_remaining);
    assign size_acc    = r_block_length | ({24'd0, i_byte_value} << {size_idx, 3'b000});
    assign size_masked = size_acc & BLOCK_SIZE_MASK;
    assign block_end   = {1'b0, pos_inc} + {1'b0, size_masked};

    // next state
    always_comb begin
        n_running        = r_running;
        n_phase          = r_phase;
        n_file_position  = r_file_position;
        n_command_start  = r_command_start;
        n_first_operand  = r_first_operand;
        n_skip_remaining = r_skip_remaining;
        n_block_length   = r_block_length;
        n_samples_total  = r_samples_total;
        n_loops_taken    = r_loops_taken;
        emit_wait = 1'b0;
        wait_amt  = 16'd0;
        emit_reg  = 1'b0;
        end_req   = 1'b0;
        end_at    = 32'd0;
        emit_jump = 1'b0;
        emit_stop = 1'b0;
        fail_req  = 1'b0;
        fail_code = ERR_TRUNCATED;
        fail_at   = 32'd0;

        if (i_action == ACT_START) begin
            n_running        = 1'b1;
            n_phase          = PH_OPCODE;
            n_file_position  = i_cfg.data_start;
            n_command_start  = i_cfg.data_start;
            n_first_operand  = 8'd0;
            n_skip_remaining = 32'd0;
            n_block_length   = 32'd0;
            n_samples_total  = 64'd0;
            n_loops_taken    = 32'd0;
        end else if (!r_running || i_action == ACT_IGNORE) begin
            n_running = r_running;
        end else if (r_phase == PH_OPCODE && r_file_position >= i_cfg.end_bound) begin
            // end bound reached: byte is not consumed
            end_req = 1'b1;
            end_at  = i_cfg.end_bound;
        end else if (i_action == ACT_EXHAUST) begin
            fail_req  = 1'b1;
            fail_code = ERR_TRUNCATED;
            fail_at   = (r_phase == PH_OPCODE) ? r_file_position : r_command_start;
        end else begin
            n_file_position = pos_inc;
            case (r_phase)
                PH_OPCODE: begin
                    n_command_start = r_file_position;
                    if (i_byte_value == OP_YM2151_WRITE) begin
                        n_phase = PH_REG_ADDR;
                    end else if (i_byte_value == OP_WAIT_N) begin
                        n_phase = PH_WAIT_LO;
                    end else if (i_byte_value == OP_WAIT_NTSC) begin
                        emit_wait = 1'b1;
                        wait_amt  = WAIT_NTSC_SAMPLES;
                    end else if (i_byte_value == OP_WAIT_PAL) begin
                        emit_wait = 1'b1;
                        wait_amt  = WAIT_PAL_SAMPLES;
                    end else if (i_byte_value[7:4] == 4'h7) begin
                        emit_wait = 1'b1;
                        wait_amt  = {12'd0, i_byte_value[3:0]} + 16'd1;
                    end else if (i_byte_value[7:4] == 4'h8) begin
                        emit_wait = 1'b1;
                        wait_amt  = {12'd0, i_byte_value[3:0]};
                    end else if (i_byte_value == OP_DATA_BLOCK) begin
                        n_phase          = PH_BLK_HDR;
                        n_skip_remaining = 32'd2;
                    end else if (i_byte_value == OP_END) begin
                        end_req = 1'b1;
                        end_at  = pos_inc;
                    end else if (!op_info.known) begin
                        fail_req  = 1'b1;
                        fail_code = ERR_UNKNOWN_OP;
                        fail_at   = r_file_position;
                    end else begin
                        n_phase          = PH_SKIP;
                        n_skip_remaining = {28'd0, op_info.len};
                    end
                end
                PH_REG_ADDR: begin
                    n_first_operand = i_byte_value;
                    n_phase         = PH_REG_DATA;
                end
                PH_REG_DATA: begin
                    emit_reg = 1'b1;
                    n_phase  = PH_OPCODE;
                end
                PH_WAIT_LO: begin
                    n_first_operand = i_byte_value;
                    n_phase         = PH_WAIT_HI;
                end
                PH_WAIT_HI: begin
                    emit_wait = 1'b1;
                    wait_amt  = {i_byte_value, r_first_operand};
                end
                PH_BLK_HDR: begin
                    n_skip_remaining = r_skip_remaining - 32'd1;
                    if (n_skip_remaining == 32'd0) begin
                        n_phase          = PH_BLK_SIZE;
                        n_skip_remaining = 32'd4;
                        n_block_length   = 32'd0;
                    end
                end
                PH_BLK_SIZE: begin
                    n_block_length   = size_acc;
                    n_skip_remaining = r_skip_remaining - 32'd1;
                    if (n_skip_remaining == 32'd0) begin
                        n_block_length = size_masked;
                        if (block_end > {1'b0, i_cfg.file_length}) begin
                            fail_req  = 1'b1;
                            fail_code = ERR_BLOCK_RANGE;
                            fail_at   = r_command_start;
                        end else begin
                            n_skip_remaining = size_masked;
                            n_phase = (size_masked == 32'd0) ? PH_OPCODE : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_skip_remaining != 32'd0) begin
                        n_skip_remaining = r_skip_remaining - 32'd1;
                    end
                    if (n_skip_remaining == 32'd0) begin
                        n_phase = PH_OPCODE;
                    end
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end

        if (emit_wait) begin
            n_samples_total = r_samples_total + {48'd0, wait_amt};
            n_phase         = PH_OPCODE;
        end

        if (end_req) begin
            n_phase = PH_OPCODE;
            if (i_cfg.loop_target != 32'd0) begin
                if (i_cfg.loop_target > i_cfg.file_length) begin
                    fail_req  = 1'b1;
                    fail_code = ERR_LOOP_RANGE;
                    fail_at   = end_at;
                end else begin
                    emit_jump       = 1'b1;
                    n_file_position = i_cfg.loop_target;
                    n_loops_taken   = r_loops_taken + 32'd1;
                end
            end else begin
                emit_stop = 1'b1;
                n_running = 1'b0;
            end
        end

        if (fail_req) begin
            n_running = 1'b0;
            n_phase   = PH_OPCODE;
        end
    end

    // result
    always_comb begin
        o_result = '0;
        o_result.sample_position = n_samples_total;
        o_result.loop_count      = n_loops_taken;
        o_res_valid = fail_req || emit_jump || emit_stop || emit_wait || emit_reg;
        if (fail_req) begin
            o_result.kind         = KIND_ERROR;
            o_result.error_code   = fail_code;
            o_result.error_offset = fail_at;
        end else if (emit_jump) begin
            o_result.kind         = KIND_LOOP_JUMP;
            o_result.error_offset = end_at;
            o_result.jump_offset  = i_cfg.loop_target;
        end else if (emit_stop) begin
            o_result.kind         = KIND_END;
            o_result.error_offset = end_at;
        end else if (emit_wait) begin
            o_result.kind         = KIND_WAIT;
            o_result.wait_samples = wait_amt;
        end else begin
            o_result.kind        = KIND_REG_WRITE;
            o_result.reg_address = emit_reg ? r_first_operand : 8'd0;
            o_result.reg_data    = emit_reg ? i_byte_value : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running        <= 1'b0;
            r_phase          <= PH_OPCODE;
            r_file_position  <= 32'd0;
            r_command_start  <= 32'd0;
            r_first_operand  <= 8'd0;
            r_skip_remaining <= 32'd0;
            r_block_length   <= 32'd0;
            r_samples_total  <= 64'd0;
            r_loops_taken    <= 32'd0;
        end else if (i_advance) begin
            r_running        <= n_running;
            r_phase          <= n_phase;
            r_file_position  <= n_file_position;
            r_command_start  <= n_command_start;
            r_first_operand  <= n_first_operand;
            r_skip_remaining <= n_skip_remaining;
            r_block_length   <= n_block_length;
            r_samples_total  <= n_samples_total;
            r_loops_taken    <= n_loops_taken;
        end
    end

endmodule

// File: rtl/vgmp_out_reg.sv
module vgmp_out_reg
    import vgmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/vgmp_checker.sv
module vgmp_checker
    import vgmp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [2:0]             o_kind,
    input logic [15:0]            o_wait_samples,
    input logic [63:0]            o_sample_position,
    input logic [1:0]             o_error_code,
    input logic [31:0]            o_error_offset,
    input logic [31:0]            o_jump_offset
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind)
            && $stable(o_sample_position) && $stable(o_error_offset))
        else $error("result changed while stalled");

    a_reg_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_REG_WRITE |->
            o_wait_samples == 16'd0 && o_error_offset == 32'd0 && o_jump_offset == 32'd0)
        else $error("register write carries stray fields");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_ERROR |-> o_error_code == ERR_TRUNCATED)
        else $error("error code set on a non-error item");

    a_jump_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_LOOP_JUMP |-> o_jump_offset == 32'd0)
        else $error("jump offset set on a non-jump item");

endmodule

bind vgm_command_stream_parser vgmp_checker u_checker (.*);

// File: dv/vgm_command_stream_parser_checker.sv
`timescale 1ns / 100ps

module vgm_command_stream_parser_checker
    import vgmp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [1:0]             i_action,
    input  logic [7:0]             i_byte_value,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_result                i_result,
    output int                     o_fail_count,
    output int                     o_pending
);

    // high nibble of the short wait opcodes
    localparam logic [3:0] OP_GROUP_WAIT_PLUS1 = 4'h7;
    localparam logic [3:0] OP_GROUP_WAIT_N     = 4'h8;

    t_cfg        cfg;
    logic        running;
    t_phase      phase;
    logic [7:0]  opcode;
    logic [7:0]  first_operand;
    logic [31:0] pos;
    logic [31:0] cmd_start;
    logic [31:0] skip_left;
    logic [31:0] block_len;
    logic [63:0] samples;
    logic [31:0] loops;

    t_result     predicted_events [$];
    int          fail_count = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // operand byte count of an opcode that belongs to another chip
    function automatic logic skip_length(input logic [7:0] op, output logic [31:0] len);
        len = 32'd0;
        if (op >= 8'h30 && op <= 8'h3F) len = 32'd1;
        else if (op >= 8'h40 && op <= 8'h4E)
            len = (cfg.format_version >= VERSION_WIDE_OPS) ? 32'd2 : 32'd1;
        else if (op == 8'h4F || op == 8'h50) len = 32'd1;
        else if (op >= 8'h51 && op <= 8'h5F) len = 32'd2;
        else if (op == 8'h64) len = 32'd3;
        else if (op == 8'h68) len = 32'd11;
        else if (op >= 8'h90 && op <= 8'h95) len = 32'(DAC_CTL_LEN[op[2:0]]);
        else if (op >= 8'hA0 && op <= 8'hBF) len = 32'd2;
        else if (op >= 8'hC0 && op <= 8'hDF) len = 32'd3;
        else if (op >= 8'hE0) len = 32'd4;
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_result make_event(input logic [2:0] kind, input logic [7:0] addr,
            input logic [7:0] data, input logic [15:0] amount, input logic [1:0] code,
            input logic [31:0] offset, input logic [31:0] jump);
        t_result r;
        r.kind            = kind;
        r.reg_address     = addr;
        r.reg_data        = data;
        r.wait_samples    = amount;
        r.sample_position = samples;
        r.loop_count      = loops;
        r.error_code      = code;
        r.error_offset    = offset;
        r.jump_offset     = jump;
        return r;
    endfunction

    function automatic t_result stop_with_error(input logic [1:0] code, input logic [31:0] at);
        running = 1'b0;
        phase   = PH_OPCODE;
        return make_event(KIND_ERROR, '0, '0, '0, code, at, '0);
    endfunction

    function automatic t_result take_wait(input logic [15:0] amount);
        samples = samples + {48'd0, amount};
        phase   = PH_OPCODE;
        return make_event(KIND_WAIT, '0, '0, amount, '0, '0, '0);
    endfunction

    // jump back to the loop point, stop when there is none, or fail when it lies beyond the file length
    function automatic t_result reach_end(input logic [31:0] at);
        phase = PH_OPCODE;
        if (cfg.loop_target != 32'd0) begin
            if (cfg.loop_target > cfg.file_length)
                return stop_with_error(ERR_LOOP_RANGE, at);
            pos   = cfg.loop_target;
            loops = loops + 32'd1;
            return make_event(KIND_LOOP_JUMP, '0, '0, '0, '0, at, cfg.loop_target);
        end
        running = 1'b0;
        return make_event(KIND_END, '0, '0, '0, '0, at, '0);
    endfunction

    function automatic logic parse_item(input logic [1:0] act, input logic [7:0] b,
            output t_result r);
        logic [31:0] len;
        logic [31:0] lane;
        logic [32:0] blk_end;
        r = '0;
        if (act == ACT_START) begin
            running       = 1'b1;
            phase         = PH_OPCODE;
            pos           = cfg.data_start;
            cmd_start     = cfg.data_start;
            opcode        = '0;
            first_operand = '0;
            skip_left     = '0;
            block_len     = '0;
            samples       = '0;
            loops         = '0;
            return 1'b0;
        end
        if (!running || (act != ACT_BYTE && act != ACT_EXHAUST)) return 1'b0;
        // end bound is checked before the byte is looked at; the byte is not consumed
        if (phase == PH_OPCODE && pos >= cfg.end_bound) begin
            r = reach_end(cfg.end_bound);
            return 1'b1;
        end
        if (act == ACT_EXHAUST) begin
            r = stop_with_error(ERR_TRUNCATED, (phase == PH_OPCODE) ? pos : cmd_start);
            return 1'b1;
        end
        pos = pos + 32'd1;
        case (phase)
            PH_OPCODE: begin
                cmd_start = pos - 32'd1;
                opcode    = b;
                if (b == OP_YM2151_WRITE) begin
                    phase = PH_REG_ADDR;
                    return 1'b0;
                end
                if (b == OP_WAIT_N) begin
                    phase = PH_WAIT_LO;
                    return 1'b0;
                end
                if (b == OP_WAIT_NTSC) r = take_wait(WAIT_NTSC_SAMPLES);
                else if (b == OP_WAIT_PAL) r = take_wait(WAIT_PAL_SAMPLES);
                else if (b[7:4] == OP_GROUP_WAIT_PLUS1) r = take_wait({12'd0, b[3:0]} + 16'd1);
                else if (b[7:4] == OP_GROUP_WAIT_N) r = take_wait({12'd0, b[3:0]});
                else if (b == OP_DATA_BLOCK) begin
                    phase     = PH_BLK_HDR;
                    skip_left = 32'd2;
                    return 1'b0;
                end else if (b == OP_END) r = reach_end(pos);
                else if (!skip_length(b, len)) r = stop_with_error(ERR_UNKNOWN_OP, cmd_start);
                else begin
                    phase     = PH_SKIP;
                    skip_left = len;
                    return 1'b0;
                end
                return 1'b1;
            end
            PH_REG_ADDR: begin
                first_operand = b;
                phase         = PH_REG_DATA;
                return 1'b0;
            end
            PH_REG_DATA: begin
                phase = PH_OPCODE;
                r = make_event(KIND_REG_WRITE, first_operand, b, '0, '0, '0, '0);
                return 1'b1;
            end
            PH_WAIT_LO: begin
                first_operand = b;
                phase         = PH_WAIT_HI;
                return 1'b0;
            end
            PH_WAIT_HI: begin
                r = take_wait({b, first_operand});
                return 1'b1;
            end
            PH_BLK_HDR: begin
                skip_left = skip_left - 32'd1;
                if (skip_left == 32'd0) begin
                    phase     = PH_BLK_SIZE;
                    skip_left = 32'd4;
                    block_len = '0;
                end
                return 1'b0;
            end
            PH_BLK_SIZE: begin
                // size arrives little endian
                lane      = 32'd4 - skip_left;
                block_len = block_len | ({24'd0, b} << (8 * lane[1:0]));
                skip_left = skip_left - 32'd1;
                if (skip_left != 32'd0) return 1'b0;
                block_len = block_len & BLOCK_SIZE_MASK;
                blk_end   = {1'b0, pos} + {1'b0, block_len};
                if (blk_end > {1'b0, cfg.file_length}) begin
                    r = stop_with_error(ERR_BLOCK_RANGE, cmd_start);
                    return 1'b1;
                end
                skip_left = block_len;
                phase     = (block_len == 32'd0) ? PH_OPCODE : PH_SKIP;
                return 1'b0;
            end
            PH_SKIP: begin
                if (skip_left > 32'd0) skip_left = skip_left - 32'd1;
                if (skip_left == 32'd0) phase = PH_OPCODE;
                return 1'b0;
            end
            default: begin
                phase = PH_OPCODE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
            input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            cfg.format_version = RST_FORMAT_VERSION;
            cfg.data_start     = RST_DATA_START;
            cfg.end_bound      = RST_END_BOUND;
            cfg.loop_target    = RST_LOOP_TARGET;
            cfg.file_length    = RST_FILE_LENGTH;
            running       = 1'b0;
            phase         = PH_OPCODE;
            opcode        = '0;
            first_operand = '0;
            pos           = '0;
            cmd_start     = '0;
            skip_left     = '0;
            block_len     = '0;
            samples       = '0;
            loops         = '0;
            predicted_events.delete();
            pending_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_result;
                if (predicted_events.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got kind %0d",
                             $time, got.kind);
                    fail_count++;
                end else begin
                    want = predicted_events.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("reg_address", want.reg_address, got.reg_address);
                    check_field("reg_data", want.reg_data, got.reg_data);
                    check_field("wait_samples", want.wait_samples, got.wait_samples);
                    check_field("sample_position", want.sample_position, got.sample_position);
                    check_field("loop_count", want.loop_count, got.loop_count);
                    check_field("error_code", want.error_code, got.error_code);
                    check_field("error_offset", want.error_offset, got.error_offset);
                    check_field("jump_offset", want.jump_offset, got.jump_offset);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_item(i_action, i_byte_value, predicted))
                    predicted_events.push_back(predicted);
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_FORMAT_VERSION: cfg.format_version = i_cfg_wdata[15:0];
                    CFG_DATA_START:     cfg.data_start     = i_cfg_wdata;
                    CFG_END_BOUND:      cfg.end_bound      = i_cfg_wdata;
                    CFG_LOOP_TARGET:    cfg.loop_target    = i_cfg_wdata;
                    CFG_FILE_LENGTH:    cfg.file_length    = i_cfg_wdata;
                    default: ;
                endcase
            end
            pending_count = predicted_events.size();
        end
    end

endmodule

// File: dv/vgm_command_stream_parser_tb.sv
`timescale 1ns / 100ps

module vgm_command_stream_parser_tb
    import vgmp_pkg::*;
;

    localparam logic [1:0] ACT_NOP             = 2'd3;
    localparam logic [7:0] OP_WAIT_SHORT_BASE  = 8'h70;
    localparam logic [7:0] OP_WAIT_NIBBLE_BASE = 8'h80;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [31:0]            i_cfg_wdata;
    logic                   i_valid;
    logic                   o_ready;
    logic [1:0]             i_action;
    logic [7:0]             i_byte_value;
    logic                   o_valid;
    logic                   i_ready;
    logic [2:0]             o_kind;
    logic [7:0]             o_reg_address;
    logic [7:0]             o_reg_data;
    logic [15:0]            o_wait_samples;
    logic [63:0]            o_sample_position;
    logic [31:0]            o_loop_count;
    logic [1:0]             o_error_code;
    logic [31:0]            o_error_offset;
    logic [31:0]            o_jump_offset;

    int          fail_count;
    int          pending_count;
    int          items_sent;
    logic        send_idle;
    logic        recv_idle;
    logic [15:0] cur_version;
    logic [31:0] cur_file_length;

    vgm_command_stream_parser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_action          (i_action),
        .i_byte_value      (i_byte_value),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_reg_address     (o_reg_address),
        .o_reg_data        (o_reg_data),
        .o_wait_samples    (o_wait_samples),
        .o_sample_position (o_sample_position),
        .o_loop_count      (o_loop_count),
        .o_error_code      (o_error_code),
        .o_error_offset    (o_error_offset),
        .o_jump_offset     (o_jump_offset)
    );

    vgm_command_stream_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_result     ({o_kind, o_reg_address, o_reg_data, o_wait_samples,
                        o_sample_position, o_loop_count, o_error_code,
                        o_error_offset, o_jump_offset}),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input logic [1:0] act, input logic [7:0] b);
        int gap;
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_action     = act;
        i_byte_value = b;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(ACT_BYTE, b);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // drain all results, then let items without a result clear the pipeline
    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apply_settings(input int style);
        logic [15:0] ver;
        logic [31:0] start;
        logic [31:0] endb;
        logic [31:0] loopt;
        logic [31:0] flen;
        if (style == 0) begin
            ver = 16'hFFFF;
            start = 32'hFFFF_FFFF;
            endb = 32'hFFFF_FFFF;
            loopt = 32'hFFFF_FFFF;
            flen = 32'hFFFF_FFFF;
        end else if (style == 1) begin
            ver = 16'h0000;
            start = 32'd64;
            endb = 32'd0;
            loopt = 32'd0;
            flen = 32'd0;
        end else begin
            case ($urandom_range(0, 3))
                0: ver = VERSION_WIDE_OPS - 16'd1;
                1: ver = VERSION_WIDE_OPS;
                2: ver = 16'($urandom_range(0, 65535));
                default: ver = RST_FORMAT_VERSION;
            endcase
            case ($urandom_range(0, 3))
                0: start = 32'd64;
                1: start = 32'd64 + 32'($urandom_range(0, 2000));
                2: start = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
                default: start = $urandom;
            endcase
            if (start < 32'd64) start = 32'd64;
            case ($urandom_range(0, 3))
                0: flen = 32'hFFFF_FFFF;
                1: flen = start + 32'($urandom_range(0, 400));
                2: flen = $urandom;
                default: flen = start + 32'($urandom_range(0, 60));
            endcase
            case ($urandom_range(0, 3))
                0: endb = 32'hFFFF_FFFF;
                1: endb = start + 32'($urandom_range(4, 80));
                2: endb = $urandom;
                default: endb = start;
            endcase
            case ($urandom_range(0, 3))
                0: loopt = 32'd0;
                1: loopt = start + 32'($urandom_range(0, 40));
                2: loopt = flen + 32'($urandom_range(1, 10));
                default: loopt = $urandom;
            endcase
        end
        write_reg(CFG_FORMAT_VERSION, {16'd0, ver});
        write_reg(CFG_DATA_START, start);
        write_reg(CFG_END_BOUND, endb);
        write_reg(CFG_LOOP_TARGET, loopt);
        write_reg(CFG_FILE_LENGTH, flen);
        cur_version     = ver;
        cur_file_length = flen;
    endtask

    // a command of another chip with the right number of operand bytes
    task automatic send_foreign_command();
        logic [7:0] op;
        int         n;
        case ($urandom_range(0, 9))
            0: begin op = 8'h30 + 8'($urandom_range(0, 15)); n = 1; end
            1: begin
                op = 8'h40 + 8'($urandom_range(0, 14));
                n  = (cur_version >= VERSION_WIDE_OPS) ? 2 : 1;
            end
            2: begin op = 8'h4F + 8'($urandom_range(0, 1)); n = 1; end
            3: begin
                op = 8'h51 + 8'($urandom_range(0, 14));
                if (op == OP_YM2151_WRITE) op = 8'h55;
                n = 2;
            end
            4: begin op = 8'h64; n = 3; end
            5: begin op = 8'h68; n = 11; end
            6: begin
                op = 8'h90 + 8'($urandom_range(0, 5));
                n  = int'(DAC_CTL_LEN[op[2:0]]);
            end
            7: begin op = 8'hA0 + 8'($urandom_range(0, 31)); n = 2; end
            8: begin op = 8'hC0 + 8'($urandom_range(0, 31)); n = 3; end
            default: begin op = 8'hE0 + 8'($urandom_range(0, 31)); n = 4; end
        endcase
        send_byte(op);
        repeat (n) send_byte(8'($urandom));
    endtask

    task automatic send_data_block();
        logic [31:0] blk_size;
        logic [31:0] payload;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) blk_size = 32'd0;
        else if (sel == 1) blk_size = 32'h8000_0000 | 32'($urandom_range(0, 3));
        else if (sel == 2 && cur_file_length < 32'h8000_0000) blk_size = BLOCK_SIZE_MASK;
        else blk_size = 32'($urandom_range(1, 6));
        send_byte(OP_DATA_BLOCK);
        send_byte(OP_END);              // compatibility byte of the block header
        send_byte(8'($urandom));        // block type
        for (int i = 0; i < 4; i++) send_byte(blk_size[8*i +: 8]);
        payload = blk_size & BLOCK_SIZE_MASK;
        if (payload < 32'd16) repeat (int'(payload)) send_byte(8'($urandom));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: send_byte(8'($urandom));
            1: send_item(ACT_EXHAUST, 8'($urandom));
            2: send_item(ACT_NOP, 8'($urandom));
            3: send_item(ACT_START, 8'($urandom));
            default: begin
                // opcodes the parser does not know
                case ($urandom_range(0, 4))
                    0: send_byte(8'($urandom_range(0, 8'h2F)));
                    1: send_byte(8'h60);
                    2: send_byte(8'h65);
                    3: send_byte(8'($urandom_range(8'h69, 8'h6F)));
                    default: send_byte(8'($urandom_range(8'h96, 8'h9F)));
                endcase
            end
        endcase
    endtask

    task automatic send_command();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            send_byte(OP_YM2151_WRITE);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end else if (sel < 38) begin
            send_byte(OP_WAIT_N);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end else if (sel < 50) begin
            case ($urandom_range(0, 3))
                0: send_byte(OP_WAIT_NTSC);
                1: send_byte(OP_WAIT_PAL);
                2: send_byte(OP_WAIT_SHORT_BASE | 8'($urandom_range(0, 15)));
                default: send_byte(OP_WAIT_NIBBLE_BASE | 8'($urandom_range(0, 15)));
            endcase
        end else if (sel < 68) begin
            send_foreign_command();
        end else if (sel < 80) begin
            send_data_block();
        end else if (sel < 84) begin
            send_byte(OP_END);
        end else begin
            send_noise();
        end
    endtask

    task automatic run_program();
        send_item(ACT_START, 8'($urandom));
        repeat ($urandom_range(2, 24)) send_command();
        case ($urandom_range(0, 3))
            0: send_byte(OP_END);
            1: send_item(ACT_EXHAUST, 8'($urandom));
            default: ;
        endcase
    endtask

    initial begin
        int style;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_FORMAT_VERSION;
        i_cfg_wdata     = 32'd0;
        i_valid         = 1'b0;
        i_action        = ACT_BYTE;
        i_byte_value    = 8'd0;
        items_sent      = 0;
        send_idle       = 1'b1;
        cur_version     = RST_FORMAT_VERSION;
        cur_file_length = RST_FILE_LENGTH;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, every wait form, wide operands, masked empty block
        send_item(ACT_START, 8'h00);
        send_byte(OP_YM2151_WRITE); send_byte(8'h00); send_byte(8'hFF);
        send_byte(OP_YM2151_WRITE); send_byte(8'hFF); send_byte(8'h00);
        send_byte(OP_WAIT_N); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(OP_WAIT_NTSC);
        send_byte(OP_WAIT_PAL);
        send_byte(OP_WAIT_SHORT_BASE | 8'h0F);
        send_byte(OP_WAIT_NIBBLE_BASE);
        send_byte(8'h4E); send_byte(8'h00); send_byte(8'h00);
        send_byte(OP_DATA_BLOCK); send_byte(OP_END); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h80);
        send_byte(8'h00);                       // unknown opcode stops the parser
        send_item(ACT_NOP, 8'hFF);
        send_item(ACT_START, 8'h00);
        send_item(ACT_EXHAUST, 8'h00);          // truncated while awaiting an opcode
        send_item(ACT_START, 8'h00);
        send_byte(OP_END);
        wait_idle();

        style = 0;
        while (items_sent < 740) begin
            apply_settings(style);
            send_idle = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 4)) run_program();
            wait_idle();
            style++;
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // result side: random stall per item, bursts without stalls, one long hold-off
    initial begin
        int stall;
        int taken;
        taken     = 0;
        recv_idle = 1'b1;
        i_ready   = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = recv_idle ? $urandom_range(0, 12) : 0;
            if (taken == 40) stall = 300;   // hold long enough to back up the input
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            taken++;
            if (taken % 50 == 0) recv_idle = ~recv_idle;
            @(negedge i_clk);
        end
    end

endmodule

// File: sim.f
rtl/vgmp_pkg.sv
rtl/vgmp_in_reg.sv
rtl/vgmp_core.sv
rtl/vgmp_out_reg.sv
rtl/vgm_command_stream_parser.sv
rtl/vgmp_checker.sv
dv/vgm_command_stream_parser_checker.sv
dv/vgm_command_stream_parser_tb.sv
